@@ rtl/core/c8x_pkg.sv @@
// shared constants, types and helper functions of the chip-8 subset execute unit
`default_nettype none

package c8x_pkg;

	localparam int MEM_DEPTH = 4096;
	localparam int SCREEN_W  = 64;
	localparam int SCREEN_H  = 32;

	localparam int MEM_AW    = $clog2(MEM_DEPTH);
	localparam int COL_AW    = $clog2(SCREEN_W);
	localparam int ROW_AW    = $clog2(SCREEN_H);
	localparam int BYTE_AW   = $clog2(SCREEN_W / 8);
	localparam int FONT_LEN  = 80;
	localparam int FONT_IW   = $clog2(FONT_LEN);

	localparam int S_TDATA_W = 32;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 40;

	localparam logic [11:0] PC_RESET = 12'h200;

	localparam logic [7:0] GLYPHS [FONT_LEN] = '{
		8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
		8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
		8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
	};

	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_EXEC  = 2'd1,
		KIND_READ  = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		OP_JUMP    = 4'h1,
		OP_SKIP_EQ = 4'h3,
		OP_LOAD    = 4'h6,
		OP_ADD     = 4'h7,
		OP_SET_I   = 4'hA,
		OP_RAND    = 4'hC,
		OP_DRAW    = 4'hD
	} op_t;

	typedef struct packed {
		logic clr_en;
		logic take;
		logic mem_wr;
		logic fb_rd;
		logic fb_cap;
		logic fetch0;
		logic fetch1;
		logic fetch2;
		logic ld_vx;
		logic exec;
		logic draw;
		logic draw_end;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic is_draw;
		logic draw_busy;
	} ctrl_sts_t;

	// 12-bit address folded onto the memory depth (depth is at least a quarter of 4096)
	function automatic logic [MEM_AW-1:0] mem_slot(input logic [11:0] a);
		logic [11:0] v;
		v = a;
		for (int i = 0; i < 3; i++) begin
			if (v >= 12'(MEM_DEPTH)) begin
				v = v - 12'(MEM_DEPTH);
			end
		end
		return v[MEM_AW-1:0];
	endfunction

	// reset content of the memory: font glyphs at the bottom, zero elsewhere
	function automatic logic [7:0] font_at(input logic [MEM_AW-1:0] a);
		logic [7:0] b;
		b = 8'h00;
		if (a < MEM_AW'(FONT_LEN)) begin
			b = GLYPHS[a[FONT_IW-1:0]];
		end
		return b;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/c8x_ram.sv @@
// generic single-write, single-read ram with registered read data
`default_nettype none

module c8x_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ rtl/core/c8x_ctrl.sv @@
// control state machine of the execute unit: sequencing and stream handshakes
`default_nettype none

module c8x_ctrl
	import c8x_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [1:0] kind,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output ctrl_cmd_t  cmd,
	input  ctrl_sts_t  sts
);

	typedef enum logic [11:0] {
		S_CLEAR  = 12'b0000_0000_0001,
		S_IDLE   = 12'b0000_0000_0010,
		S_WRITE  = 12'b0000_0000_0100,
		S_FB_RD0 = 12'b0000_0000_1000,
		S_FB_RD1 = 12'b0000_0001_0000,
		S_FETCH0 = 12'b0000_0010_0000,
		S_FETCH1 = 12'b0000_0100_0000,
		S_FETCH2 = 12'b0000_1000_0000,
		S_LOAD_X = 12'b0001_0000_0000,
		S_EXEC   = 12'b0010_0000_0000,
		S_DRAW   = 12'b0100_0000_0000,
		S_DONE   = 12'b1000_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic   m_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_en = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (s_axis_tvalid) begin
					cmd.take = 1'b1;
					unique case (kind_t'(kind))
						KIND_WRITE: state_d = S_WRITE;
						KIND_EXEC:  state_d = S_FETCH0;
						KIND_READ:  state_d = S_FB_RD0;
						default:    state_d = S_DONE;
					endcase
				end
			end
			S_WRITE: begin
				cmd.mem_wr = 1'b1;
				state_d    = S_DONE;
			end
			S_FB_RD0: begin
				cmd.fb_rd = 1'b1;
				state_d   = S_FB_RD1;
			end
			S_FB_RD1: begin
				cmd.fb_cap = 1'b1;
				state_d    = S_DONE;
			end
			S_FETCH0: begin
				cmd.fetch0 = 1'b1;
				state_d    = S_FETCH1;
			end
			S_FETCH1: begin
				cmd.fetch1 = 1'b1;
				state_d    = S_FETCH2;
			end
			S_FETCH2: begin
				cmd.fetch2 = 1'b1;
				state_d    = S_LOAD_X;
			end
			S_LOAD_X: begin
				cmd.ld_vx = 1'b1;
				state_d   = S_EXEC;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = sts.is_draw ? S_DRAW : S_DONE;
			end
			S_DRAW: begin
				cmd.draw = 1'b1;
				if (!sts.draw_busy) begin
					cmd.draw_end = 1'b1;
					state_d      = S_DONE;
				end
			end
			S_DONE: begin
				if (!m_valid_q || m_axis_tready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = m_valid_q;

`ifndef SYNTHESIS
	a_load_into_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_valid_q || m_axis_tready))
		else $error("result loaded over a beat not yet taken");

	a_exec_starts_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.take && kind == KIND_EXEC) |=> (state_q == S_FETCH0))
		else $error("execute beat did not start an instruction fetch");
`endif

endmodule

`default_nettype wire

@@ rtl/core/c8x_datapath.sv @@
// datapath: memory, framebuffer, machine registers, sprite draw and result register
`default_nettype none

module c8x_datapath
	import c8x_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [11:0] address,
	input  logic [7:0]  write_data,
	input  logic [7:0]  random_byte,
	input  ctrl_cmd_t   cmd,
	output ctrl_sts_t   sts,
	output logic        fault,
	output logic [15:0] opcode_done,
	output logic [11:0] pc_after,
	output logic        collision,
	output logic [7:0]  read_data
);

	// latched input beat
	logic [11:0] addr_q;
	logic [7:0]  wdata_q;
	logic [7:0]  rnd_q;

	// machine state
	logic [MEM_AW-1:0] clr_cnt_q;
	logic [11:0]       pc_q;
	logic [11:0]       index_q;
	logic [7:0]        vregs_q [16];

	// per-item working registers
	logic [7:0] hi_q, lo_q;
	logic [7:0] vx_q, vy_q;
	logic       fault_q, coll_q;
	logic [7:0] rdata_q;

	// draw pipeline
	logic [3:0]        row_q;
	logic              pend_s1;
	logic [ROW_AW-1:0] py_s1;
	logic              hit_q;

	// result register
	logic        out_fault_q;
	logic [15:0] out_word_q;
	logic [11:0] out_pc_q;
	logic        out_coll_q;
	logic [7:0]  out_rdata_q;

	// ram ports
	logic              mem_we;
	logic [MEM_AW-1:0] mem_waddr, mem_raddr;
	logic [7:0]        mem_wdata, mem_rdata;
	logic              fb_we;
	logic [ROW_AW-1:0] fb_waddr, fb_raddr;
	logic [SCREEN_W-1:0] fb_wdata, fb_rdata;

	logic [3:0]          vsel;
	logic [7:0]          vreg_rd;
	logic                issue;
	logic [ROW_AW-1:0]   py_d;
	logic [SCREEN_W-1:0] mask;
	logic                op_known;
	logic [3:0]          x_idx;

	assign x_idx   = hi_q[3:0];
	assign vsel    = cmd.ld_vx ? x_idx : lo_q[7:4];
	assign vreg_rd = vregs_q[vsel];
	assign issue   = (row_q < lo_q[3:0]);
	assign py_d    = vy_q[ROW_AW-1:0] + ROW_AW'(row_q);

	always_comb begin
		unique case (op_t'(hi_q[7:4]))
			OP_JUMP, OP_SKIP_EQ, OP_LOAD, OP_ADD, OP_SET_I, OP_RAND, OP_DRAW: op_known = 1'b1;
			default: op_known = 1'b0;
		endcase
	end

	// sprite byte placed on its screen row, msb at column x0, wrapping at the right edge
	always_comb begin
		mask = '0;
		for (int c = 0; c < 8; c++) begin
			mask[COL_AW'(vx_q[COL_AW-1:0] + COL_AW'(c))] = mem_rdata[7-c];
		end
	end

	assign sts.clr_last  = (clr_cnt_q == MEM_AW'(MEM_DEPTH - 1));
	assign sts.is_draw   = (hi_q[7:4] == OP_DRAW);
	assign sts.draw_busy = issue || pend_s1;

	// memory ports
	assign mem_we    = cmd.clr_en || cmd.mem_wr;
	assign mem_waddr = cmd.clr_en ? clr_cnt_q : mem_slot(addr_q);
	assign mem_wdata = cmd.clr_en ? font_at(clr_cnt_q) : wdata_q;

	always_comb begin
		priority if (cmd.fetch0) begin
			mem_raddr = mem_slot(pc_q);
		end else if (cmd.fetch1) begin
			mem_raddr = mem_slot(pc_q + 12'd1);
		end else begin
			mem_raddr = mem_slot(index_q + 12'(row_q));
		end
	end

	// framebuffer ports, one 64-pixel screen row per entry
	assign fb_we    = (cmd.clr_en && (clr_cnt_q < MEM_AW'(SCREEN_H))) || (cmd.draw && pend_s1);
	assign fb_waddr = cmd.clr_en ? clr_cnt_q[ROW_AW-1:0] : py_s1;
	assign fb_wdata = cmd.clr_en ? '0 : (fb_rdata ^ mask);
	assign fb_raddr = cmd.fb_rd ? addr_q[BYTE_AW +: ROW_AW] : py_d;

	c8x_ram #(
		.WIDTH (8),
		.DEPTH (MEM_DEPTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	c8x_ram #(
		.WIDTH (SCREEN_W),
		.DEPTH (SCREEN_H)
	) u_fb (
		.clk   (clk),
		.we    (fb_we),
		.waddr (fb_waddr),
		.wdata (fb_wdata),
		.raddr (fb_raddr),
		.rdata (fb_rdata)
	);

	// architectural registers and control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
			pc_q      <= PC_RESET;
			index_q   <= '0;
			for (int i = 0; i < 16; i++) begin
				vregs_q[i] <= '0;
			end
			row_q   <= '0;
			pend_s1 <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			if (cmd.clr_en) begin
				clr_cnt_q <= clr_cnt_q + MEM_AW'(1);
			end
			if (cmd.fetch2) begin
				pc_q <= pc_q + 12'd2;
			end
			if (cmd.exec) begin
				unique case (op_t'(hi_q[7:4]))
					OP_JUMP:    pc_q <= {hi_q[3:0], lo_q};
					OP_SKIP_EQ: begin
						if (vx_q == lo_q) begin
							pc_q <= pc_q + 12'd2;
						end
					end
					OP_LOAD:    vregs_q[x_idx] <= lo_q;
					OP_ADD:     vregs_q[x_idx] <= vx_q + lo_q;
					OP_SET_I:   index_q <= {hi_q[3:0], lo_q};
					OP_RAND:    vregs_q[x_idx] <= rnd_q & lo_q;
					default:    ;
				endcase
				row_q   <= '0;
				pend_s1 <= 1'b0;
				hit_q   <= 1'b0;
			end else if (cmd.draw) begin
				pend_s1 <= issue;
				if (issue) begin
					row_q <= row_q + 4'd1;
				end
				if (pend_s1) begin
					hit_q <= hit_q | (|(fb_rdata & mask));
				end
			end
			if (cmd.draw_end) begin
				vregs_q[15] <= {7'd0, hit_q};
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			addr_q  <= address;
			wdata_q <= write_data;
			rnd_q   <= random_byte;
			hi_q    <= '0;
			lo_q    <= '0;
			fault_q <= 1'b0;
			coll_q  <= 1'b0;
			rdata_q <= '0;
		end
		if (cmd.fetch1) begin
			hi_q <= mem_rdata;
		end
		if (cmd.fetch2) begin
			lo_q <= mem_rdata;
		end
		if (cmd.fb_cap) begin
			rdata_q <= fb_rdata[{addr_q[BYTE_AW-1:0], 3'b000} +: 8];
		end
		if (cmd.ld_vx) begin
			vx_q <= vreg_rd;
		end
		if (cmd.exec) begin
			vy_q    <= vreg_rd;
			fault_q <= !op_known;
		end
		if (cmd.draw && issue) begin
			py_s1 <= py_d;
		end
		if (cmd.draw_end) begin
			coll_q <= hit_q;
		end
		if (cmd.out_load) begin
			out_fault_q <= fault_q;
			out_word_q  <= {hi_q, lo_q};
			out_pc_q    <= pc_q;
			out_coll_q  <= coll_q;
			out_rdata_q <= rdata_q;
		end
	end

	assign fault       = out_fault_q;
	assign opcode_done = out_word_q;
	assign pc_after    = out_pc_q;
	assign collision   = out_coll_q;
	assign read_data   = out_rdata_q;

`ifndef SYNTHESIS
	a_pc_moves_only_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.fetch2 || cmd.exec) |=> $stable(pc_q))
		else $error("program counter changed outside fetch or execute");

	a_draw_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.draw |-> (row_q <= lo_q[3:0]))
		else $error("sprite row counter ran past the sprite height");
`endif

endmodule

`default_nettype wire

@@ rtl/core/chip8_subset_execute_unit.sv @@
// top level of the chip-8 subset execute unit: controller plus datapath
`default_nettype none

// usage
//   input beats on s_axis_*: tuser carries the kind (write memory byte, execute one
//   instruction, read framebuffer byte), tdata carries address, write data and random byte.
//   every accepted beat gives exactly one result beat on m_axis_*.
// sequence, from the accepted beat to the load of the result register
//   memory write: a write state. framebuffer read: a read state, then a capture state.
//   unused kind: straight to the result. instruction: the fetch states, a register
//   read state and the execute state; a sprite draw adds a draw state that lasts until
//   every row is written. the next beat is taken once the result is loaded.
//   these steps are set by the single read port of the memory: the instruction word
//   comes in one byte a cycle, and sprite rows stream one a cycle, each row doing a
//   read-modify-write of one 64-pixel framebuffer row.
// reset
//   after arst_n is released the unit runs a clearing pass over the whole memory (one
//   byte per cycle, loading the font at the bottom and clearing the 32 framebuffer rows);
//   s_axis_tready stays low until it ends.
// back pressure
//   results sit in an output register; one further beat is accepted and worked on
//   while a result waits, then the unit holds until m_axis_tready takes the old beat.
module chip8_subset_execute_unit
	import c8x_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [S_TDATA_W-1:0] s_axis_tdata,  // address[11:0], write_data[19:12], random_byte[27:20], zero pad
	input  logic [S_TUSER_W-1:0] s_axis_tuser,  // kind[1:0]
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [M_TDATA_W-1:0] m_axis_tdata   // fault[0], opcode_done[16:1], pc_after[28:17],
	                                            // collision[29], read_data[37:30], zero pad
);

	ctrl_cmd_t   cmd;
	ctrl_sts_t   sts;
	logic        fault;
	logic [15:0] opcode_done;
	logic [11:0] pc_after;
	logic        collision;
	logic [7:0]  read_data;

	// sequencing and handshakes
	c8x_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.kind          (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.cmd           (cmd),
		.sts           (sts)
	);

	// storage, execution and result register
	c8x_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.address     (s_axis_tdata[11:0]),
		.write_data  (s_axis_tdata[19:12]),
		.random_byte (s_axis_tdata[27:20]),
		.cmd         (cmd),
		.sts         (sts),
		.fault       (fault),
		.opcode_done (opcode_done),
		.pc_after    (pc_after),
		.collision   (collision),
		.read_data   (read_data)
	);

	// result beat packing, first field in the lowest bits
	assign m_axis_tdata = {2'b00, read_data, collision, pc_after, opcode_done, fault};

endmodule

`default_nettype wire
